>>> rtl/core/rset_pkg.sv
// ----------------------------------------------------------------------------
// Randomized set table package
// Item types, operation codes and error codes shared by the set table files.
// ----------------------------------------------------------------------------
package rset_pkg;

  localparam int VALUE_W = 32;
  localparam int DRAW_W  = 16;
  localparam int DRAW_BW = 4;   // bits of a bit index into the draw
  localparam int COUNT_W = 7;   // width of the reported element count

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PICK   = 2'd2;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
    logic [DRAW_W-1:0]         random_draw;
  } rset_in_t;

  typedef struct packed {
    logic                      success;
    logic signed [VALUE_W-1:0] picked_value;
    logic [1:0]                error_code;
    logic [COUNT_W-1:0]        element_count;
  } rset_out_t;

endpackage

>>> rtl/core/rset_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/randomized_set_table_top.sv
// ----------------------------------------------------------------------------
// Randomized set table
// Set of distinct signed values in a dense array with insert, remove and
// random pick, driven by a small sequencer around one compare/subtract unit.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_ready   | rset_in_t  (mode, value, draw)
//  out_     | output    | out_valid / out_ready | rset_out_t (one result per item)
//
// Insert and remove scan the store one entry at a time (RAM read, then
// compare). A pick runs a 16-step restoring modulo of the draw by the
// count and then one RAM read. Reset is synchronous and clears the count;
// the store needs no clearing. A new item is taken while a result waits in
// the output register; the sequencer only holds in its final state while
// that register is still full.
// ----------------------------------------------------------------------------
module randomized_set_table_top #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rset_pkg::rset_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rset_pkg::rset_out_t out_data
);

  import rset_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_LWR   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PRD   = 4'd6;
  localparam logic [3:0] S_PWAIT = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [DRAW_W-1:0]   draw_r, draw_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [DRAW_BW-1:0]  bit_r, bit_nxt;
  logic                found_r, found_nxt;
  logic                succ_r, succ_nxt;
  logic [VALUE_W-1:0]  pick_r, pick_nxt;
  logic [1:0]          err_r, err_nxt;
  logic                out_valid_r, out_valid_nxt;
  rset_out_t           out_data_r, out_data_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

  // Modulo unit: one compare-and-subtract step of the restoring modulo.
  logic [CW:0]         trial;
  logic [CW:0]         trial_sub;
  logic                trial_ge;
  logic [CW-1:0]       idx_inc;
  logic [CW+COUNT_W-1:0] count_ext;

  assign trial     = {rem_r, draw_r[bit_r]};
  assign trial_ge  = trial >= {1'b0, count_r};
  assign trial_sub = trial - {1'b0, count_r};
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign count_ext = (CW + COUNT_W)'(count_r);

  rset_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    value_nxt     = value_r;
    draw_nxt      = draw_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    found_nxt     = found_r;
    succ_nxt      = succ_r;
    pick_nxt      = pick_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = value_r;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          value_nxt = in_data.value;
          draw_nxt  = in_data.random_draw;
          idx_nxt   = '0;
          rem_nxt   = '0;
          bit_nxt   = DRAW_BW'(DRAW_W - 1);
          found_nxt = 1'b0;
          succ_nxt  = 1'b0;
          pick_nxt  = '0;
          err_nxt   = ERR_NONE;
          if (in_data.mode == MODE_INSERT || in_data.mode == MODE_REMOVE) begin
            state_nxt = (count_r == '0) ? S_UPD : S_RD;
          end else if (in_data.mode == MODE_PICK) begin
            if (count_r == '0) begin
              err_nxt   = ERR_EMPTY;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_DIV;
            end
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (ram_rdata == value_r) begin
          found_nxt = 1'b1;
          state_nxt = S_UPD;
        end else if (idx_inc == count_r) begin
          state_nxt = S_UPD;
        end else begin
          idx_nxt   = idx_inc[AW-1:0];
          state_nxt = S_RD;
        end
      end
      S_UPD: begin
        state_nxt = S_FIN;
        if (mode_r == MODE_INSERT) begin
          if (!found_r) begin
            if (count_r >= CW'(CAPACITY)) begin
              err_nxt = ERR_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              succ_nxt  = 1'b1;
            end
          end
        end else if (found_r) begin
          // Fetch the last entry; it moves into the freed slot next cycle.
          ram_re    = 1'b1;
          ram_raddr = AW'(count_r - CW'(1));
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        count_nxt = count_r - CW'(1);
        succ_nxt  = 1'b1;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        rem_nxt = trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
        if (bit_r == '0) begin
          state_nxt = S_PRD;
        end else begin
          bit_nxt = bit_r - DRAW_BW'(1);
        end
      end
      S_PRD: begin
        ram_re    = 1'b1;
        ram_raddr = rem_r[AW-1:0];
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        pick_nxt  = ram_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.success       = succ_r;
          out_data_nxt.picked_value  = pick_r;
          out_data_nxt.error_code    = err_r;
          out_data_nxt.element_count = count_ext[COUNT_W-1:0];
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    value_r    <= value_nxt;
    draw_r     <= draw_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    found_r    <= found_nxt;
    succ_r     <= succ_nxt;
    pick_r     <= pick_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // The count never passes the capacity of the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // The count moves by at most one per item.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("element count jumped");

  // The store is written only when an insert appends or a remove refills a slot.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_UPD || state_r == S_LWR))
    else $error("store written outside an update");

  // A new result appears only out of the final sequencer state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ready)) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the final state");

endmodule

>>> test/randomized_set_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Randomized set table checker
// Watches both channels of the set table, keeps its own copy of the stored
// values and count, predicts one result per accepted item and compares each
// returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module randomized_set_table_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rset_pkg::rset_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rset_pkg::rset_out_t out_data,
  output int                  fail_count,
  output int                  pending_results
);

  import rset_pkg::*;

  logic [VALUE_W-1:0] held_values [CAPACITY];
  int                 held_count;
  rset_out_t          predicted_results [$];
  rset_out_t          new_result;
  rset_out_t          oldest_result;
  int                 mismatches;

  // Applies one operation to the shadow set and returns what the block owes.
  function automatic rset_out_t apply_set_op(rset_in_t item);
    rset_out_t res;
    int        slot;
    res  = '0;
    slot = -1;
    for (int i = 0; i < held_count; i++) begin
      if (slot < 0 && held_values[i] == item.value) begin
        slot = i;
      end
    end
    case (item.mode)
      MODE_INSERT: begin
        if (slot < 0) begin
          if (held_count >= CAPACITY) begin
            res.error_code = ERR_FULL;
          end else begin
            held_values[held_count] = item.value;
            held_count++;
            res.success = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (slot >= 0) begin
          // The last entry fills the hole so the store stays dense.
          held_values[slot] = held_values[held_count-1];
          held_count--;
          res.success = 1'b1;
        end
      end
      MODE_PICK: begin
        if (held_count == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.picked_value = held_values[int'(item.random_draw) % held_count];
        end
      end
      default: ;
    endcase
    res.element_count = COUNT_W'(held_count);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      predicted_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        new_result = apply_set_op(in_data);
        predicted_results.insert(predicted_results.size(), new_result);
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, out_data);
          mismatches++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("success", VALUE_W'(oldest_result.success),
                      VALUE_W'(out_data.success));
          check_field("picked_value", oldest_result.picked_value, out_data.picked_value);
          check_field("error_code", VALUE_W'(oldest_result.error_code),
                      VALUE_W'(out_data.error_code));
          check_field("element_count", VALUE_W'(oldest_result.element_count),
                      VALUE_W'(out_data.element_count));
        end
      end
    end
    fail_count      <= mismatches;
    pending_results <= predicted_results.size();
  end

endmodule

>>> test/tb_randomized_set_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Randomized set table testbench
// Drives insert, remove, pick and unused-mode items into the set table
// from a pool of distinct values, fills the table past capacity, and
// varies sender gaps and receiver stalls, including one long receiver
// hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_randomized_set_table_top;
  import rset_pkg::*;

  localparam int         CAPACITY    = 64;
  localparam int         POOL_SIZE   = 72;
  localparam int         HOLD_CYCLES = 400;
  localparam int         QUIET_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  rset_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rset_out_t out_data;
  int        fail_count;
  int        pending_results;

  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 holds_requested = 0;
  int                 holds_served    = 0;
  int                 quiet_cycles    = 0;
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  logic [VALUE_W-1:0] candidate;
  bit                 is_new;

  randomized_set_table_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  randomized_set_table_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rset_in_t set_op(logic [1:0] mode, logic [VALUE_W-1:0] value,
                                      logic [DRAW_W-1:0] draw);
    rset_in_t item;
    item.mode        = mode;
    item.value       = value;
    item.random_draw = draw;
    return item;
  endfunction

  // Mostly pool values so inserts collide and removes find their target.
  function automatic rset_in_t random_set_op(int insert_pct, int remove_pct);
    int                 roll;
    logic [1:0]         mode;
    logic [VALUE_W-1:0] value;
    logic [DRAW_W-1:0]  draw;
    roll = $urandom_range(99);
    if (roll < insert_pct) mode = MODE_INSERT;
    else if (roll < insert_pct + remove_pct) mode = MODE_REMOVE;
    else if (roll < 99) mode = MODE_PICK;
    else mode = MODE_UNUSED;
    if ($urandom_range(9) == 0) value = $urandom;
    else value = value_pool[$urandom_range(POOL_SIZE-1)];
    if ($urandom_range(2) == 0) draw = DRAW_W'($urandom_range(2*CAPACITY));
    else draw = DRAW_W'($urandom_range(16'hFFFF));
    return set_op(mode, value, draw);
  endfunction

  task automatic send_set_op(rset_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_mix(int count, int insert_pct, int remove_pct);
    repeat (count) send_set_op(random_set_op(insert_pct, remove_pct));
  endtask

  // Inserts pool entries in order, so the table is sure to overflow.
  task automatic fill_from_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      send_set_op(set_op(MODE_INSERT, value_pool[i], DRAW_W'($urandom_range(16'hFFFF))));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (holds_requested != holds_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_randomized_set_table_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      do begin
        candidate = $urandom;
        is_new    = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (value_pool[j] == candidate) is_new = 1'b0;
        end
      end while (!is_new);
      value_pool[i] = candidate;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-set cases, extremes, duplicates and the swap-on-remove.
    send_set_op(set_op(MODE_PICK,   $urandom, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'd5, DRAW_W'($urandom_range(16'hFFFF))));
    send_set_op(set_op(MODE_UNUSED, $urandom, DRAW_W'($urandom_range(16'hFFFF))));
    send_set_op(set_op(MODE_INSERT, 32'h8000_0000, 16'hFFFF));
    send_set_op(set_op(MODE_INSERT, 32'h7FFF_FFFF, 16'h0000));
    send_set_op(set_op(MODE_INSERT, 32'h0000_0000, 16'h1234));
    send_set_op(set_op(MODE_INSERT, 32'hFFFF_FFFF, 16'h8000));
    send_set_op(set_op(MODE_INSERT, 32'h7FFF_FFFF, 16'h0001));
    send_set_op(set_op(MODE_PICK,   $urandom, 16'h0000));
    send_set_op(set_op(MODE_PICK,   $urandom, 16'hFFFF));
    send_set_op(set_op(MODE_PICK,   $urandom, 16'h0002));
    send_set_op(set_op(MODE_REMOVE, 32'h8000_0000, 16'h0000));
    send_set_op(set_op(MODE_PICK,   $urandom, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'd12345, 16'hFFFF));
    send_set_op(set_op(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
    send_set_op(set_op(MODE_INSERT, 32'h8000_0000, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'hFFFF_FFFF, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'h7FFF_FFFF, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'h0000_0000, 16'h0000));
    send_set_op(set_op(MODE_REMOVE, 32'h8000_0000, 16'h0000));
    send_set_op(set_op(MODE_PICK,   32'hFFFF_FFFF, 16'hFFFF));

    fill_from_pool();
    run_mix(30, 10, 10);

    send_idle_pct = 77;
    run_mix(180, 50, 30);

    // Long receiver hold-off while items keep coming, so the input stalls.
    send_idle_pct   = 0;
    holds_requested <= holds_requested + 1;
    run_mix(40, 60, 20);

    recv_stall_pct = 77;
    run_mix(150, 25, 55);

    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_mix(200, 45, 35);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_from_pool();
    run_mix(40, 40, 40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_randomized_set_table_top OK");
    end else begin
      $display("tb_randomized_set_table_top NOT OK");
    end
    $finish;
  end

endmodule
